>>> hw/rtl/humidity_sensor_frame_checker_top_assert.svh
// Assertion macros for the humidity sensor frame checker.
`ifndef HUMIDITY_SENSOR_FRAME_CHECKER_TOP_ASSERT_SVH
`define HUMIDITY_SENSOR_FRAME_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HSFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hsfc assertion failed");

// Next-cycle implication, disabled during reset.
`define HSFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hsfc assertion failed");

`endif

>>> hw/rtl/hsfc_pkg.sv
`timescale 1ns / 1ps

package hsfc_pkg;

    localparam logic [7:0]  CRC_INIT  = 8'hFF;
    localparam logic [7:0]  CRC_POLY  = 8'h31;
    localparam logic [15:0] ID_MASK   = 16'h083F;
    localparam logic [15:0] ID_VALUE  = 16'h0807;
    localparam logic [6:0]  PCT_SCALE = 7'd100;

    // last byte index of each frame kind
    localparam logic [2:0] LAST_ID   = 3'd2;
    localparam logic [2:0] LAST_MEAS = 3'd5;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_ABORT = 1'b1;
    localparam logic KIND_ID   = 1'b0;
    localparam logic KIND_MEAS = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CRC   = 2'd1,
        ST_ID    = 2'd2,
        ST_ABORT = 2'd3
    } t_status;

    // role of a byte within its 3-byte word group
    typedef enum logic [1:0] {
        SLOT_HIGH = 2'd0,
        SLOT_LOW  = 2'd1,
        SLOT_CRC  = 2'd2
    } t_slot;

    typedef struct packed {
        logic       kind;
        logic       action;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [14:0] humidity_pct_q8;
        logic [15:0] humidity_raw;
        logic [15:0] sensor_id;
    } t_result;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic t_slot word_slot(input logic [2:0] pos);
        t_slot s;
        unique case (pos)
            3'd0, 3'd3, 3'd6: s = SLOT_HIGH;
            3'd1, 3'd4, 3'd7: s = SLOT_LOW;
            3'd2, 3'd5:       s = SLOT_CRC;
            default:          s = SLOT_HIGH;
        endcase
        return s;
    endfunction

endpackage

>>> hw/rtl/hsfc_in_stage.sv
`timescale 1ns / 1ps

module hsfc_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hsfc_pkg::t_in_item  i_item,
    output logic                o_valid,
    output hsfc_pkg::t_in_item  o_item,
    input  logic                i_take
);

    logic               r_valid;
    hsfc_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

>>> hw/rtl/hsfc_frame_core.sv
`timescale 1ns / 1ps

module hsfc_frame_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  hsfc_pkg::t_in_item  i_item,
    output logic                o_item_take,
    input  logic                i_out_free,
    output logic                o_emit,
    output hsfc_pkg::t_result   o_result
);

    logic [2:0]  r_pos,    n_pos;
    logic [7:0]  r_crc,    n_crc;
    logic        r_failed, n_failed;
    logic [7:0]  r_high,   n_high;
    logic [15:0] r_word,   n_word;

    hsfc_pkg::t_slot w_slot;
    logic [2:0]      w_last;
    logic            w_abort;
    logic            w_frame_end;
    logic [22:0]     w_pct_full;
    logic            w_bad_crc;

    assign o_item_take = i_item_valid && i_out_free;
    assign w_slot      = hsfc_pkg::word_slot(r_pos);
    assign w_last      = (i_item.kind == hsfc_pkg::KIND_MEAS) ? hsfc_pkg::LAST_MEAS
                                                               : hsfc_pkg::LAST_ID;
    assign w_abort     = (i_item.action == hsfc_pkg::ACT_ABORT);
    assign w_frame_end = !w_abort && !(r_pos < w_last);

    // word and CRC tracking for the current byte
    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_failed = r_failed;
        n_high   = r_high;
        n_word   = r_word;
        case (w_slot)
            hsfc_pkg::SLOT_HIGH: begin
                n_crc  = hsfc_pkg::crc8_byte(hsfc_pkg::CRC_INIT, i_item.data);
                n_high = i_item.data;
            end
            hsfc_pkg::SLOT_LOW: begin
                n_crc  = hsfc_pkg::crc8_byte(r_crc, i_item.data);
                n_word = {r_high, i_item.data};
            end
            default: begin
                if (r_crc != i_item.data) begin
                    n_failed = 1'b1;
                end
                n_crc = hsfc_pkg::CRC_INIT;
            end
        endcase
        if (!w_frame_end) begin
            n_pos = r_pos + 3'd1;
        end
    end

    // an end byte that is not a CRC byte leaves its word unchecked
    assign w_bad_crc  = n_failed || (w_slot != hsfc_pkg::SLOT_CRC);
    assign w_pct_full = 23'(n_word) * 23'(hsfc_pkg::PCT_SCALE);

    always_comb begin
        o_emit   = w_abort || w_frame_end;
        o_result = '0;
        if (w_abort) begin
            o_result.status = hsfc_pkg::ST_ABORT;
        end else begin
            if (w_bad_crc) begin
                o_result.status = hsfc_pkg::ST_CRC;
            end else if (i_item.kind == hsfc_pkg::KIND_ID &&
                         (n_word & hsfc_pkg::ID_MASK) != hsfc_pkg::ID_VALUE) begin
                o_result.status = hsfc_pkg::ST_ID;
            end else begin
                o_result.status = hsfc_pkg::ST_OK;
            end
            if (i_item.kind == hsfc_pkg::KIND_ID) begin
                o_result.sensor_id = n_word;
            end else begin
                o_result.humidity_raw    = n_word;
                o_result.humidity_pct_q8 = w_pct_full[22:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= hsfc_pkg::CRC_INIT;
            r_failed <= 1'b0;
            r_high   <= '0;
            r_word   <= '0;
        end else if (o_item_take) begin
            if (o_emit) begin
                r_pos    <= '0;
                r_crc    <= hsfc_pkg::CRC_INIT;
                r_failed <= 1'b0;
                r_high   <= '0;
                r_word   <= '0;
            end else begin
                r_pos    <= n_pos;
                r_crc    <= n_crc;
                r_failed <= n_failed;
                r_high   <= n_high;
                r_word   <= n_word;
            end
        end
    end

endmodule

>>> hw/rtl/hsfc_out_stage.sv
`timescale 1ns / 1ps

module hsfc_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  hsfc_pkg::t_result  i_result,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output hsfc_pkg::t_result  o_result
);

    logic              r_valid;
    hsfc_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

>>> hw/rtl/humidity_sensor_frame_checker_top.sv
`timescale 1ns / 1ps

// Humidity sensor frame checker. Takes sensor response bytes one transaction
// at a time on the slave stream and reports one result transaction per frame
// (or per abort) on the master stream. tuser[1] picks the frame kind for each
// byte: 0 = 3-byte identification frame, 1 = 6-byte measurement frame;
// tuser[0] = 1 aborts the frame and reports the abort status right away. Each
// 2-byte word is followed by a CRC-8 (poly 0x31, init 0xFF, MSB first).
// Result status: 0 ok, 1 CRC mismatch (also for a frame cut short by a kind
// change), 2 identifier mismatch ((id & 0x083F) != 0x0807), 3 aborted.
// Timing: one byte per clock sustained while m_axis_tready stays high. An
// accepted byte lands in the input register; when the core takes it, the CRC
// step, word assembly and the humidity scaling (raw*100 >> 8, one 16x7
// multiply) settle combinationally and load the result register, so a result
// passes through the input register and the result register. While a result
// waits on m_axis_tready the core takes no byte; the input register holds at
// most one more byte, then s_axis_tready drops until the result is taken.

`include "humidity_sensor_frame_checker_top_assert.svh"

module humidity_sensor_frame_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [0] action, [1] frame_kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] sensor_id, [31:16] humidity_raw,
                                        // [46:32] humidity_pct_q8, [47] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    hsfc_pkg::t_in_item w_s_item;
    hsfc_pkg::t_in_item w_core_item;
    hsfc_pkg::t_result  w_core_result;
    hsfc_pkg::t_result  w_out_result;
    logic               w_core_valid;
    logic               w_take;
    logic               w_out_free;
    logic               w_emit;

    assign w_s_item.action = s_axis_tuser[0];
    assign w_s_item.kind   = s_axis_tuser[1];
    assign w_s_item.data   = s_axis_tdata;

    hsfc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_s_item),
        .o_valid (w_core_valid),
        .o_item  (w_core_item),
        .i_take  (w_take)
    );

    hsfc_frame_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_core_valid),
        .i_item       (w_core_item),
        .o_item_take  (w_take),
        .i_out_free   (w_out_free),
        .o_emit       (w_emit),
        .o_result     (w_core_result)
    );

    // a result only loads when a byte is actually consumed
    hsfc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_take && w_emit),
        .i_result (w_core_result),
        .o_free   (w_out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out_result)
    );

    assign m_axis_tdata = {1'b0, w_out_result.humidity_pct_q8,
                           w_out_result.humidity_raw, w_out_result.sensor_id};
    assign m_axis_tuser = w_out_result.status;

    // an accepted byte is always held in the input register next cycle
    `HSFC_ASSERT_NEXT(a_in_capture, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, w_core_valid)

    // an abort result carries no words
    `HSFC_ASSERT_NOW(a_abort_zero, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser == hsfc_pkg::ST_ABORT, m_axis_tdata == 48'd0)

    // identifier mismatch only comes from identification frames
    `HSFC_ASSERT_NOW(a_id_frame_only, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser == hsfc_pkg::ST_ID, m_axis_tdata[47:16] == 32'd0)

endmodule
